// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define SFDP_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define SFDP_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/sfdp_pkg.sv -----
// ----------------------------------------------------------------------------
// sfdp_pkg
// Types, character codes and constants shared by the field parser modules.
// ----------------------------------------------------------------------------
package sfdp_pkg;

   localparam int CHAR_W   = 8;
   localparam int SLOT_W   = 4;
   localparam int MANT_W   = 64;
   localparam int PLACES_W = 5;
   localparam int REAL_W   = 48;
   localparam int INT_W    = 32;
   localparam int FOUND_W  = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'd45;
   localparam logic [CHAR_W-1:0] CH_PERIOD = 8'd46;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'd47;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'd48;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'd57;

   localparam logic [CSR_IDX_W-1:0] CSR_INT_SLOT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REAL1_SLOT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REAL2_SLOT = 2'd2;

   localparam logic [SLOT_W-1:0] INT_SLOT_RESET   = 4'd5;
   localparam logic [SLOT_W-1:0] REAL1_SLOT_RESET = 4'd6;
   localparam logic [SLOT_W-1:0] REAL2_SLOT_RESET = 4'd7;
   localparam logic [SLOT_W-1:0] SLASH_MAX        = 4'd15;

   // Queue between the character front end and the conversion back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [1:0] {
      JOB_INT    = 2'd0,
      JOB_REAL1  = 2'd1,
      JOB_REAL2  = 2'd2,
      JOB_FINISH = 2'd3
   } job_kind_type;

   typedef struct packed {
      job_kind_type              kind;
      logic [MANT_W-1:0]         mantissa;
      logic                      negative;
      logic [PLACES_W-1:0]       places;
      logic                      overflow;
   } sfdp_job_type;

   typedef struct packed {
      logic [SLOT_W-1:0] int_slot;
      logic [SLOT_W-1:0] real1_slot;
      logic [SLOT_W-1:0] real2_slot;
   } sfdp_slots_type;

   // Powers of ten up to 10^19; larger exponents clamp to 10^19.
   function automatic logic [MANT_W-1:0] pow10(input logic [PLACES_W-1:0] n);
      logic [MANT_W-1:0] p;
      case (n)
         5'd0:    p = 64'd1;
         5'd1:    p = 64'd10;
         5'd2:    p = 64'd100;
         5'd3:    p = 64'd1000;
         5'd4:    p = 64'd10000;
         5'd5:    p = 64'd100000;
         5'd6:    p = 64'd1000000;
         5'd7:    p = 64'd10000000;
         5'd8:    p = 64'd100000000;
         5'd9:    p = 64'd1000000000;
         5'd10:   p = 64'd10000000000;
         5'd11:   p = 64'd100000000000;
         5'd12:   p = 64'd1000000000000;
         5'd13:   p = 64'd10000000000000;
         5'd14:   p = 64'd100000000000000;
         5'd15:   p = 64'd1000000000000000;
         5'd16:   p = 64'd10000000000000000;
         5'd17:   p = 64'd100000000000000000;
         5'd18:   p = 64'd1000000000000000000;
         default: p = 64'd10000000000000000000;
      endcase
      return p;
   endfunction

endpackage

// ----- rtl/core/sfdp_front.sv -----
// ----------------------------------------------------------------------------
// sfdp_front
// Character front end: counts slashes, builds the field mantissa and queues
// one conversion job per closed field plus a finish job per string.
// ----------------------------------------------------------------------------
module sfdp_front #(
   parameter int MAX_DIGITS = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sfdp_pkg::CHAR_W-1:0]   req_tdata,
   input  logic                          req_tlast,
   input  sfdp_pkg::sfdp_slots_type      slots,
   output logic                          q_push,
   output sfdp_pkg::sfdp_job_type        q_push_job,
   input  logic                          q_ready,
   output logic                          finish_pending
);
   import sfdp_pkg::*;

   localparam logic [MANT_W-1:0]   DIGIT_LIMIT = pow10(PLACES_W'(MAX_DIGITS - 1));
   localparam logic [PLACES_W-1:0] PLACES_MAX  = PLACES_W'(MAX_DIGITS);

   logic [SLOT_W-1:0]   slash_ff, slash_in;
   logic                in_field_ff, in_field_in;
   logic [MANT_W-1:0]   mant_ff, mant_in;
   logic                neg_ff, neg_in;
   logic                period_ff, period_in;
   logic [PLACES_W-1:0] places_ff, places_in;
   logic                empty_ff, empty_in;
   logic                ovf_ff, ovf_in;
   logic                fin_pend_ff, fin_pend_in;

   logic                accept;
   logic                is_real;
   logic [3:0]          digit;
   logic [MANT_W-1:0]   mant_x10;

   assign req_tready     = q_ready && !fin_pend_ff;
   assign accept         = req_tvalid && req_tready;
   assign finish_pending = fin_pend_ff;
   assign is_real        = slash_ff != slots.int_slot;
   assign digit          = 4'(req_tdata - CH_ZERO);
   assign mant_x10       = (mant_ff << 3) + (mant_ff << 1) + MANT_W'(digit);

   always_comb begin
      slash_in    = slash_ff;
      in_field_in = in_field_ff;
      mant_in     = mant_ff;
      neg_in      = neg_ff;
      period_in   = period_ff;
      places_in   = places_ff;
      empty_in    = empty_ff;
      ovf_in      = ovf_ff;
      fin_pend_in = fin_pend_ff;
      q_push      = 1'b0;
      q_push_job  = '{kind: JOB_FINISH, mantissa: mant_ff, negative: neg_ff,
                      places: places_ff, overflow: ovf_ff};

      if (fin_pend_ff) begin
         if (q_ready) begin
            q_push      = 1'b1;
            fin_pend_in = 1'b0;
            ovf_in      = 1'b0;
         end
      end else if (accept) begin
         if (req_tdata == CH_SLASH) begin
            // Closing a field hands it to the back end; precedence follows the
            // integer, first real, second real order.
            if (in_field_ff) begin
               if (slash_ff == slots.int_slot) begin
                  q_push = 1'b1;
                  q_push_job.kind = JOB_INT;
               end else if (slash_ff == slots.real1_slot) begin
                  q_push = 1'b1;
                  q_push_job.kind = JOB_REAL1;
               end else if (slash_ff == slots.real2_slot) begin
                  q_push = 1'b1;
                  q_push_job.kind = JOB_REAL2;
               end
            end
            if (slash_ff != SLASH_MAX) begin
               slash_in = slash_ff + 4'd1;
            end
            in_field_in = (slash_in == slots.int_slot) || (slash_in == slots.real1_slot) ||
                          (slash_in == slots.real2_slot);
            if (in_field_in) begin
               mant_in   = '0;
               neg_in    = 1'b0;
               period_in = 1'b0;
               places_in = '0;
               empty_in  = 1'b1;
            end
         end else if (in_field_ff) begin
            if (req_tdata == CH_MINUS && empty_ff) begin
               neg_in = 1'b1;
            end else if (req_tdata inside {[CH_ZERO:CH_NINE]}) begin
               if (is_real && period_ff) begin
                  if (places_ff >= PLACES_MAX || mant_ff >= DIGIT_LIMIT) begin
                     ovf_in = 1'b1;
                  end else begin
                     mant_in   = mant_x10;
                     places_in = places_ff + 5'd1;
                  end
               end else if (mant_ff >= DIGIT_LIMIT) begin
                  mant_in = '1;
                  ovf_in  = 1'b1;
               end else begin
                  mant_in = mant_x10;
               end
            end else if (req_tdata == CH_PERIOD && is_real && !period_ff) begin
               period_in = 1'b1;
            end
            empty_in = 1'b0;
         end

         if (req_tlast) begin
            slash_in    = '0;
            in_field_in = 1'b0;
            mant_in     = '0;
            neg_in      = 1'b0;
            period_in   = 1'b0;
            places_in   = '0;
            empty_in    = 1'b1;
            if (q_push) begin
               // A closing slash on the last character: finish waits in fin_pend_ff for queue room.
               fin_pend_in = 1'b1;
            end else begin
               q_push              = 1'b1;
               q_push_job.kind     = JOB_FINISH;
               q_push_job.overflow = ovf_in;
               ovf_in              = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slash_ff    <= '0;
         in_field_ff <= 1'b0;
         mant_ff     <= '0;
         neg_ff      <= 1'b0;
         period_ff   <= 1'b0;
         places_ff   <= '0;
         empty_ff    <= 1'b1;
         ovf_ff      <= 1'b0;
         fin_pend_ff <= 1'b0;
      end else begin
         slash_ff    <= slash_in;
         in_field_ff <= in_field_in;
         mant_ff     <= mant_in;
         neg_ff      <= neg_in;
         period_ff   <= period_in;
         places_ff   <= places_in;
         empty_ff    <= empty_in;
         ovf_ff      <= ovf_in;
         fin_pend_ff <= fin_pend_in;
      end
   end

endmodule

// ----- rtl/core/sfdp_queue.sv -----
// ----------------------------------------------------------------------------
// sfdp_queue
// Small first-in first-out job queue between the front and back ends.
// ----------------------------------------------------------------------------
module sfdp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sfdp_pkg::sfdp_job_type  push_job,
   output logic                    push_ready,
   input  logic                    pop,
   output sfdp_pkg::sfdp_job_type  head_job,
   output logic                    empty
);
   import sfdp_pkg::*;

   sfdp_job_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign empty      = count_ff == '0;
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/sfdp_back.sv -----
// ----------------------------------------------------------------------------
// sfdp_back
// Conversion back end: saturates integers, converts reals to fixed point
// with a bit-serial divider, and assembles the string result.
// ----------------------------------------------------------------------------
module sfdp_back #(
   parameter int FRACTION_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sfdp_pkg::sfdp_job_type         head_job,
   input  logic                           q_empty,
   output logic                           q_pop,
   output logic                           dividing,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sfdp_pkg::REAL_W-1:0]    out_first_real,
   output logic [sfdp_pkg::REAL_W-1:0]    out_second_real,
   output logic [sfdp_pkg::INT_W-1:0]     out_integer,
   output logic [sfdp_pkg::FOUND_W-1:0]   out_found,
   output logic                           out_overflow
);
   import sfdp_pkg::*;

   // Long division of mantissa * 2^FRACTION_BITS, one quotient bit per step.
   localparam int STEPS = MANT_W + FRACTION_BITS;
   localparam int CNT_W = $clog2(STEPS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } back_state_type;

   back_state_type      state_ff, state_in;

   logic [REAL_W-1:0]   held_r1_ff, held_r2_ff;
   logic [INT_W-1:0]    held_int_ff;
   logic [FOUND_W-1:0]  held_found_ff;
   logic                held_ovf_ff;

   logic [MANT_W-1:0]   dvd_ff, rem_ff, div_p_ff;
   logic [REAL_W-1:0]   quot_ff;
   logic                big_ff, neg_ff;
   job_kind_type        kind_ff;
   logic [CNT_W-1:0]    cnt_ff;

   logic                rsp_valid_ff;
   logic                out_free;

   logic [MANT_W:0]     rem_shift, rem_diff;
   logic                rem_ge;

   logic [MANT_W-1:0]   int_lim, int_mag;
   logic                int_sat;
   logic [INT_W-1:0]    int_val;

   logic [REAL_W-1:0]   real_lim, real_mag, real_val;
   logic                real_sat;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign dividing   = state_ff == ST_DIV;

   assign q_pop = (state_ff == ST_IDLE) && !q_empty &&
                  ((head_job.kind != JOB_FINISH) || out_free);

   // Integer field: clamp magnitude, then apply the sign.
   assign int_lim = head_job.negative ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
   assign int_sat = head_job.mantissa > int_lim;
   assign int_mag = int_sat ? int_lim : head_job.mantissa;
   assign int_val = head_job.negative ? (~int_mag[INT_W-1:0] + 1'b1) : int_mag[INT_W-1:0];

   // Divider step.
   assign rem_shift = {rem_ff, dvd_ff[MANT_W-1]};
   assign rem_diff  = rem_shift - {1'b0, div_p_ff};
   assign rem_ge    = rem_shift >= {1'b0, div_p_ff};

   // Real field: any quotient bit above the 48-bit result forces saturation.
   assign real_lim = neg_ff ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
   assign real_sat = big_ff || (quot_ff > real_lim);
   assign real_mag = real_sat ? real_lim : quot_ff;
   assign real_val = neg_ff ? (~real_mag + 1'b1) : real_mag;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop && (head_job.kind == JOB_REAL1 || head_job.kind == JOB_REAL2)) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_r1_ff    <= '0;
         held_r2_ff    <= '0;
         held_int_ff   <= '0;
         held_found_ff <= '0;
         held_ovf_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         // A new result may replace one that leaves on the same edge.
         if (q_pop && head_job.kind == JOB_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (q_pop) begin
            case (head_job.kind)
               JOB_INT: begin
                  held_int_ff      <= int_val;
                  held_found_ff[0] <= 1'b1;
                  held_ovf_ff      <= held_ovf_ff | int_sat;
               end
               JOB_FINISH: begin
                  held_r1_ff    <= '0;
                  held_r2_ff    <= '0;
                  held_int_ff   <= '0;
                  held_found_ff <= '0;
                  held_ovf_ff   <= 1'b0;
               end
               default: ;
            endcase
         end
         if (state_ff == ST_DONE) begin
            if (kind_ff == JOB_REAL1) begin
               held_r1_ff       <= real_val;
               held_found_ff[1] <= 1'b1;
            end else begin
               held_r2_ff       <= real_val;
               held_found_ff[2] <= 1'b1;
            end
            held_ovf_ff <= held_ovf_ff | real_sat;
         end
      end
   end

   // Output payload register, loaded as the finish job leaves the queue.
   always_ff @(posedge clock) begin
      if (q_pop && head_job.kind == JOB_FINISH) begin
         out_first_real  <= held_r1_ff;
         out_second_real <= held_r2_ff;
         out_integer     <= held_int_ff;
         out_found       <= held_found_ff;
         out_overflow    <= held_ovf_ff | head_job.overflow;
      end
   end

   // Divider datapath.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         dvd_ff   <= head_job.mantissa;
         div_p_ff <= pow10(head_job.places);
         neg_ff   <= head_job.negative;
         kind_ff  <= head_job.kind;
         rem_ff   <= '0;
         quot_ff  <= '0;
         big_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else if (state_ff == ST_DIV) begin
         dvd_ff  <= {dvd_ff[MANT_W-2:0], 1'b0};
         rem_ff  <= rem_ge ? rem_diff[MANT_W-1:0] : rem_shift[MANT_W-1:0];
         quot_ff <= {quot_ff[REAL_W-2:0], rem_ge};
         big_ff  <= big_ff | quot_ff[REAL_W-1];
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

endmodule

// ----- rtl/core/slash_field_decimal_parser.sv -----
// ----------------------------------------------------------------------------
// slash_field_decimal_parser: slash-delimited decimal field parser
// Results: registered as the finish job leaves the queue, behind the string's field jobs.
// Throughput: 1 character per cycle while the queue has room and no finish job is pending.
// Reset: synchronous, active high; slots return to 5, 6 and 7 and all string state clears.
// ----------------------------------------------------------------------------
module slash_field_decimal_parser #(
   parameter int FRACTION_BITS = 32,
   parameter int MAX_DIGITS    = 18
) (
   input  logic          clock,
   input  logic          reset,

   // Character stream. tdata: [7:0] char_code. tlast: last_char.
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tlast,

   // Result stream. tdata: [47:0] first_real, [95:48] second_real,
   // [127:96] integer_value, [130:128] found_mask, [131] overflow, [135:132] zero.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,

   // Slot register writes: index 0 integer, 1 first real, 2 second real.
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [3:0]    csr_wdata
);
   import sfdp_pkg::*;

   // The three slot registers select which slash-delimited fields are parsed.
   // A write to an index outside the list is ignored.
   sfdp_slots_type slots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff.int_slot   <= INT_SLOT_RESET;
         slots_ff.real1_slot <= REAL1_SLOT_RESET;
         slots_ff.real2_slot <= REAL2_SLOT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INT_SLOT:   slots_ff.int_slot   <= csr_wdata;
            CSR_REAL1_SLOT: slots_ff.real1_slot <= csr_wdata;
            CSR_REAL2_SLOT: slots_ff.real2_slot <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The front end consumes one character per transfer and turns every closed
   // field into a job. The final character of a string adds a finish job that
   // carries the digit overflow seen anywhere in the string.
   sfdp_job_type q_push_job, q_head_job;
   logic         q_push, q_ready, q_pop, q_empty;
   logic         fin_pend;
   logic         back_dividing;

   sfdp_front #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .slots          (slots_ff),
      .q_push         (q_push),
      .q_push_job     (q_push_job),
      .q_ready        (q_ready),
      .finish_pending (fin_pend)
   );

   // The queue lets the front keep taking characters while the back end
   // works through a real-field division.
   sfdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_job   (q_head_job),
      .empty      (q_empty)
   );

   logic [REAL_W-1:0]  res_first_real, res_second_real;
   logic [INT_W-1:0]   res_integer;
   logic [FOUND_W-1:0] res_found;
   logic               res_overflow;

   // The back end holds the converted fields of the current string and loads
   // the result register when the finish job arrives.
   sfdp_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (q_head_job),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .dividing        (back_dividing),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .out_first_real  (res_first_real),
      .out_second_real (res_second_real),
      .out_integer     (res_integer),
      .out_found       (res_found),
      .out_overflow    (res_overflow)
   );

   assign rsp_tdata = {4'b0000, res_overflow, res_found, res_integer,
                       res_second_real, res_first_real};

   // Transfer of the final character of a string.
   logic last_accept;
   assign last_accept = req_tvalid && req_tready && req_tlast;

   `include "assert_macros.svh"

   // The front end must never offer a job the queue cannot take.
   `SFDP_ASSERT_IMPL(a_queue_no_overflow, q_push, q_ready, "job pushed into a full queue")
   // No job may leave the queue while the divider is busy.
   `SFDP_ASSERT_IMPL(a_no_pop_while_div, back_dividing, !q_pop, "job popped during division")
   // The last character always leaves a finish job queued or pending.
   `SFDP_ASSERT_NEXT(a_last_gives_finish, last_accept, !q_empty || fin_pend, "finish job lost")

endmodule

// ----- sim/slash_field_decimal_parser_tb.sv -----
// ----------------------------------------------------------------------------
// slash_field_decimal_parser_tb: self-checking bench for the field parser
// Streams character strings into the parser under several slot settings and
// compares every result transfer against a cycle-free software prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module slash_field_decimal_parser_tb;
   import sfdp_pkg::*;

   localparam int FRAC_BITS    = 32;
   localparam int DIGIT_LIMIT  = 18;
   // Worst-case back-end work: four queued real fields, each a full divider run.
   localparam int DRAIN_CYCLES = 420;
   localparam int PHASE_CHARS  = 100;
   localparam int RANDOM_CHARS = 800;
   localparam int MIN_LINES    = 40;
   localparam int HOLD_CYCLES  = 400;

   // One result as the parser should report it.
   typedef struct {
      logic [REAL_W-1:0]  first_real;
      logic [REAL_W-1:0]  second_real;
      logic [INT_W-1:0]   int_value;
      logic [FOUND_W-1:0] found;
      logic               ovf;
   } parse_record_type;

   // -------------------------------------------------------------------------
   // Scoreboard: a shadow of the parser's per-string state. Every accepted
   // character is folded in; a last character queues the predicted record.
   // -------------------------------------------------------------------------
   class field_parse_checker;
      logic [SLOT_W-1:0]   int_slot, real1_slot, real2_slot;
      logic [SLOT_W-1:0]   slash_count;
      bit                  in_field, negative, period_seen, field_empty;
      logic [MANT_W-1:0]   mantissa;
      logic [PLACES_W-1:0] places;
      logic [REAL_W-1:0]   held_real1, held_real2;
      logic [INT_W-1:0]    held_int;
      logic [FOUND_W-1:0]  held_found;
      bit                  held_ovf;
      parse_record_type    expected_records[$];
      int                  mismatches;

      function new();
         int_slot   = INT_SLOT_RESET;
         real1_slot = REAL1_SLOT_RESET;
         real2_slot = REAL2_SLOT_RESET;
         mismatches = 0;
         clear_line();
      endfunction

      function void set_slots(logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b,
                              logic [SLOT_W-1:0] c);
         int_slot   = a;
         real1_slot = b;
         real2_slot = c;
      endfunction

      function void clear_line();
         slash_count = '0;
         in_field    = 0;
         mantissa    = '0;
         negative    = 0;
         period_seen = 0;
         places      = '0;
         field_empty = 1;
         held_real1  = '0;
         held_real2  = '0;
         held_int    = '0;
         held_found  = '0;
         held_ovf    = 0;
      endfunction

      function logic [MANT_W-1:0] ten_to(int n);
         logic [MANT_W-1:0] p;
         p = 64'd1;
         for (int k = 0; k < n; k++) p = p * 64'd10;
         return p;
      endfunction

      // Mantissa over ten to the places, as a signed fixed-point value that
      // is truncated toward zero and clamped to the 48-bit signed range.
      function logic [REAL_W-1:0] to_fixed();
         logic [MANT_W-1:0] lim, p, q, r, mag, frac;
         lim  = negative ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
         p    = ten_to((places > 19) ? 19 : int'(places));
         q    = mantissa / p;
         r    = mantissa % p;
         frac = '0;
         if (q > (lim >> FRAC_BITS)) begin
            mag      = lim;
            held_ovf = 1;
         end else begin
            for (int k = 0; k < FRAC_BITS; k++) begin
               r    = r << 1;
               frac = frac << 1;
               if (r >= p) begin
                  r       = r - p;
                  frac[0] = 1'b1;
               end
            end
            mag = (q << FRAC_BITS) + frac;
            if (mag > lim) begin
               mag      = lim;
               held_ovf = 1;
            end
         end
         mag = negative ? (~mag + 64'd1) : mag;
         return mag[REAL_W-1:0];
      endfunction

      function logic [INT_W-1:0] to_integer();
         logic [MANT_W-1:0] lim, mag;
         lim = negative ? 64'h8000_0000 : 64'h7FFF_FFFF;
         mag = mantissa;
         if (mag > lim) begin
            mag      = lim;
            held_ovf = 1;
         end
         mag = negative ? (~mag + 64'd1) : mag;
         return mag[INT_W-1:0];
      endfunction

      function void take_digit(logic [3:0] digit, bit is_real);
         logic [MANT_W-1:0] limit;
         limit = ten_to(DIGIT_LIMIT - 1);
         if (is_real && period_seen) begin
            // Fraction digits past the precision limit are dropped.
            if (places >= DIGIT_LIMIT || mantissa >= limit) begin
               held_ovf = 1;
            end else begin
               mantissa = mantissa * 64'd10 + 64'(digit);
               places   = places + 1'b1;
            end
         end else if (mantissa >= limit) begin
            mantissa = '1;
            held_ovf = 1;
         end else begin
            mantissa = mantissa * 64'd10 + 64'(digit);
         end
      endfunction

      function void close_field();
         if (slash_count == int_slot) begin
            held_int      = to_integer();
            held_found[0] = 1'b1;
         end else if (slash_count == real1_slot) begin
            held_real1    = to_fixed();
            held_found[1] = 1'b1;
         end else if (slash_count == real2_slot) begin
            held_real2    = to_fixed();
            held_found[2] = 1'b1;
         end
         in_field = 0;
      endfunction

      function void take_char(logic [CHAR_W-1:0] c, bit last);
         bit               is_real;
         parse_record_type rec;
         if (c == CH_SLASH) begin
            if (in_field) close_field();
            if (slash_count != SLASH_MAX) slash_count = slash_count + 1'b1;
            if (slash_count == real1_slot || slash_count == real2_slot ||
                slash_count == int_slot) begin
               in_field    = 1;
               mantissa    = '0;
               negative    = 0;
               period_seen = 0;
               places      = '0;
               field_empty = 1;
            end
         end else if (in_field) begin
            is_real = (slash_count != int_slot);
            if (c == CH_MINUS && field_empty) begin
               negative = 1;
            end else if (c >= CH_ZERO && c <= CH_NINE) begin
               take_digit(4'(c - CH_ZERO), is_real);
            end else if (c == CH_PERIOD && is_real && !period_seen) begin
               period_seen = 1;
            end
            field_empty = 0;
         end
         if (last) begin
            rec.first_real  = held_real1;
            rec.second_real = held_real2;
            rec.int_value   = held_int;
            rec.found       = held_found;
            rec.ovf         = held_ovf;
            expected_records.push_back(rec);
            clear_line();
         end
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic [135:0] d);
         parse_record_type want;
         if (expected_records.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, d);
            mismatches++;
            return;
         end
         want = expected_records.pop_front();
         compare_field("first_real",    64'(want.first_real),  64'(d[47:0]));
         compare_field("second_real",   64'(want.second_real), 64'(d[95:48]));
         compare_field("integer_value", 64'(want.int_value),   64'(d[127:96]));
         compare_field("found_mask",    64'(want.found),       64'(d[130:128]));
         compare_field("overflow",      64'(want.ovf),         64'(d[131]));
         compare_field("padding",       64'd0,                 64'(d[135:132]));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input has a known value from
   // time zero; reset is asserted only at the start of the run.
   // -------------------------------------------------------------------------
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;   // [7:0] char_code
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic [135:0] rsp_tdata;        // first_real, second_real, integer_value,
                                   // found_mask, overflow, zero padding
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [3:0]   csr_wdata = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   slash_field_decimal_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   field_parse_checker parse_sb = new();

   // Shared controls between the sender and the receiver.
   bit                quiet_run    = 0;   // no idling on either side
   bit                hold_request = 0;   // ask the receiver for a long hold-off
   logic [SLOT_W-1:0] cur_slots [3];
   logic [7:0]        char_line [$];
   int                random_chars = 0;
   int                random_lines = 0;

   // The run is bounded well above the slowest legal schedule: every
   // character closing a real field, each needing a full divider run.
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver. Result transfers are checked on the edge that completes them.
   // Ready drops at random, with odds of 11 in 100, except during quiet phases, and a
   // long hold-off can be requested so that the queue inside the block fills
   // and the character stream stalls behind it.
   // -------------------------------------------------------------------------
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) parse_sb.check_result(rsp_tdata);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 0;
            hold_left    = HOLD_CYCLES;
            rsp_tready  <= 1'b0;
         end else begin
            rsp_tready <= quiet_run || ($urandom_range(0, 99) >= 11);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks.
   // -------------------------------------------------------------------------

   // Offer one character and wait for its transfer. Valid stays high into
   // the next character, so it is only lowered when a gap is inserted; each
   // gap cycle is drawn with the same odds as the receiver's idle cycles.
   task automatic send_char(input logic [7:0] c, input logic last);
      while (!quiet_run && $urandom_range(0, 99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_sb.take_char(c, last);
   endtask

   task automatic send_text(input string text);
      for (int k = 0; k < text.len(); k++) send_char(text[k], k == text.len() - 1);
   endtask

   task automatic send_line();
      foreach (char_line[k]) send_char(char_line[k], k == char_line.size() - 1);
      random_chars += char_line.size();
      random_lines++;
   endtask

   // Wait until every predicted result has been seen, then give the back
   // end time to finish any conversion that was still in flight.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (parse_sb.expected_records.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Slot registers are written back to back on an idle block.
   task automatic write_slots(input logic [3:0] a, input logic [3:0] b,
                              input logic [3:0] c);
      drain_block();
      csr_we    <= 1'b1;
      csr_index <= CSR_INT_SLOT;
      csr_wdata <= a;
      @(posedge clock);
      csr_index <= CSR_REAL1_SLOT;
      csr_wdata <= b;
      @(posedge clock);
      csr_index <= CSR_REAL2_SLOT;
      csr_wdata <= c;
      @(posedge clock);
      csr_we <= 1'b0;
      parse_sb.set_slots(a, b, c);
      cur_slots[0] = a;
      cur_slots[1] = b;
      cur_slots[2] = c;
   endtask

   function automatic logic [7:0] rand_digit();
      return 8'(CH_ZERO + $urandom_range(0, 9));
   endfunction

   // Text of one field: mostly signed numbers with or without a period,
   // plus noise bytes, empty fields, stray signs and integer-sized values.
   task automatic add_field_text();
      int kind, ndig, dot_at;
      kind = $urandom_range(0, 9);
      case (kind)
         6: begin
            repeat ($urandom_range(1, 4)) char_line.push_back(8'($urandom_range(0, 255)));
         end
         7: begin
         end
         8: begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 3))
                  0:       char_line.push_back(CH_MINUS);
                  1:       char_line.push_back(CH_PERIOD);
                  default: char_line.push_back(rand_digit());
               endcase
            end
         end
         9: begin
            if ($urandom_range(0, 1)) char_line.push_back(CH_MINUS);
            char_line.push_back(8'(CH_ZERO + $urandom_range(1, 3)));
            repeat ($urandom_range(8, 10)) char_line.push_back(rand_digit());
         end
         default: begin
            if ($urandom_range(0, 1)) char_line.push_back(CH_MINUS);
            ndig   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 21)
                                                 : $urandom_range(0, 8);
            dot_at = $urandom_range(0, 1) ? $urandom_range(0, ndig) : -1;
            for (int k = 0; k <= ndig; k++) begin
               if (k == dot_at) char_line.push_back(CH_PERIOD);
               if (k < ndig) char_line.push_back(rand_digit());
            end
         end
      endcase
   endtask

   // One string. Most are slash-separated records deep enough to reach and
   // close the configured fields; some stop short, leave the last field
   // open, or are plain noise.
   task automatic build_line();
      int max_slot, nslash, pos;
      char_line.delete();
      max_slot = cur_slots[0];
      if (cur_slots[1] > max_slot) max_slot = cur_slots[1];
      if (cur_slots[2] > max_slot) max_slot = cur_slots[2];
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 12)) char_line.push_back(8'($urandom_range(0, 255)));
      end else begin
         nslash = max_slot + $urandom_range(0, 2);
         if ($urandom_range(0, 7) == 0) nslash = $urandom_range(1, 17);
         if (nslash == 0) nslash = 1;
         for (int k = 1; k <= nslash; k++) begin
            char_line.push_back(CH_SLASH);
            pos = (k > 15) ? 15 : k;
            // Fields nobody reads are mostly left empty to keep lines short.
            if (pos == cur_slots[0] || pos == cur_slots[1] || pos == cur_slots[2] ||
                $urandom_range(0, 3) == 0) begin
               if (k < nslash || $urandom_range(0, 3) == 0) add_field_text();
            end
         end
      end
      if (char_line.size() == 0) char_line.push_back(8'($urandom_range(0, 255)));
   endtask

   // -------------------------------------------------------------------------
   // Main sequence: directed strings, then random phases over slot settings.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int               phase, phase_chars;
      logic [SLOT_W-1:0] a, b, c;
      cur_slots[0] = INT_SLOT_RESET;
      cur_slots[1] = REAL1_SLOT_RESET;
      cur_slots[2] = REAL2_SLOT_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Slots as they come out of reset.
      send_text("/////12/-3.25/0.5/");

      write_slots(4'd1, 4'd2, 4'd3);
      // Negative integer clamp, negative real, a second period ignored.
      send_text("/-2147483649/-0.5/12.3.4/");
      // Late minus and period in the integer field; a lone minus that is
      // closed; a real field left open.
      send_text("/9-./-/");
      // Too many integer digits in a real, too many fraction digits.
      send_text("//123456789012345678901/0.0000000000000000001/");
      send_text("/2147483648/");
      // A one-character string and a string ending inside a field.
      send_text("A");
      send_text("/5");

      phase = 0;
      while (random_chars < RANDOM_CHARS || random_lines < MIN_LINES) begin
         case (phase)
            0:       begin a = 4'd5;  b = 4'd6;  c = 4'd7;  end
            1:       begin a = 4'd1;  b = 4'd2;  c = 4'd3;  end
            2:       begin a = 4'd0;  b = 4'd15; c = 4'd1;  end
            3:       begin a = 4'd15; b = 4'd14; c = 4'd13; end
            4:       begin a = 4'd3;  b = 4'd3;  c = 4'd3;  end
            5:       begin a = 4'd2;  b = 4'd2;  c = 4'd4;  end
            6:       begin a = 4'd15; b = 4'd15; c = 4'd15; end
            7:       begin a = 4'd0;  b = 4'd0;  c = 4'd0;  end
            default: begin
               a = 4'($urandom_range(0, 15));
               b = 4'($urandom_range(0, 15));
               c = 4'($urandom_range(0, 15));
            end
         endcase
         // The pause for all results happens inside the register write.
         write_slots(a, b, c);
         quiet_run = (phase == 1);
         if (phase == 2) hold_request = 1;
         phase_chars = 0;
         while (phase_chars < PHASE_CHARS) begin
            build_line();
            phase_chars += char_line.size();
            send_line();
         end
         phase++;
      end
      quiet_run = 0;

      drain_block();
      if (parse_sb.mismatches == 0 && parse_sb.expected_records.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sfdp_pkg.sv
rtl/core/sfdp_front.sv
rtl/core/sfdp_queue.sv
rtl/core/sfdp_back.sv
rtl/core/slash_field_decimal_parser.sv
sim/slash_field_decimal_parser_tb.sv
